[sv/two_key_press_lock_debouncer_macros.svh]
// Assertion macros shared by the debouncer RTL.
`ifndef TWO_KEY_PRESS_LOCK_DEBOUNCER_MACROS_SVH
`define TWO_KEY_PRESS_LOCK_DEBOUNCER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define TKPL_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("debouncer assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define TKPL_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("debouncer assertion failed");

`endif

[sv/tkpl_pkg.sv]
// Shared types and constants of the two-key press-lock debouncer.
`default_nettype none
package tkpl_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] LockoutReset = CfgW'(80);
  localparam logic [CfgW-1:0] StableReset  = CfgW'(80);

  localparam logic [CfgIdxW-1:0] CfgIdxLockout = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxStable  = CfgIdxW'(1);

  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_ADD  = 2'd1,
    EVT_SUB  = 2'd2
  } event_e;

  // Per-key debounce state.
  typedef struct packed {
    logic             armed;
    logic [TimeW-1:0] last_press;
    logic [TimeW-1:0] rel_start;
  } key_state_t;

  // Per-key sample of one request.
  typedef struct packed {
    logic level;
    logic fall;
  } key_sample_t;

  typedef struct packed {
    logic [CfgW-1:0] lockout;
    logic [CfgW-1:0] stable;
  } cfg_t;

endpackage
`default_nettype wire

[sv/tkpl_key.sv]
// Edge acceptance and release rearm logic for one key.
`default_nettype none
module tkpl_key import tkpl_pkg::*; (
  input  key_state_t       state_i,
  input  key_sample_t      sample_i,
  input  logic [TimeW-1:0] now_i,
  input  logic             poll_i,
  input  cfg_t             cfg_i,
  output key_state_t       state_o,
  output logic             accept_o
);

  logic [TimeW-1:0] since_press;
  logic [TimeW-1:0] since_release;
  key_state_t       after_edge;

  assign since_press = now_i - state_i.last_press;
  assign accept_o = sample_i.fall && state_i.armed && sample_i.level &&
                    (since_press >= TimeW'(cfg_i.lockout));

  always_comb begin
    after_edge = state_i;
    if (accept_o) begin
      after_edge.armed      = 1'b0;
      after_edge.rel_start  = '0;
      after_edge.last_press = now_i;
    end
  end

  assign since_release = now_i - after_edge.rel_start;

  // A released key starts its timer first and is rearmed on a later poll.
  always_comb begin
    state_o = after_edge;
    if (poll_i) begin
      if (!sample_i.level) begin
        if (after_edge.rel_start == '0) begin
          state_o.rel_start = now_i;
        end else if (since_release >= TimeW'(cfg_i.stable)) begin
          state_o.armed = 1'b1;
        end
      end else begin
        state_o.rel_start = '0;
      end
    end
  end

endmodule
`default_nettype wire

[sv/two_key_press_lock_debouncer.sv]
// Requests pass from an input register to a result register, which decouple the two sides.
// Throughput: one request per cycle while the output is not stalled.
// The key state is updated as a request moves from the input to the result register.
// Reset (rst_ni low, asynchronous) arms both keys, clears times, event and pending flag,
// and loads both timing registers with 80 ms.
`default_nettype none
module two_key_press_lock_debouncer import tkpl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic               add_pressed_i,
  input  logic               sub_pressed_i,
  input  logic               add_fall_i,
  input  logic               sub_fall_i,
  input  logic               poll_event_i,
  input  logic               poll_pending_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_code_o,
  output logic               edge_pending_o
);

  `include "two_key_press_lock_debouncer_macros.svh"

  cfg_t             cfg_q;
  logic             in_valid_q;
  logic [TimeW-1:0] now_q;
  key_sample_t      add_smp_q, sub_smp_q;
  logic             poll_event_q, poll_pending_q;
  logic             out_valid_q;
  event_e           event_code_q;
  logic             edge_pending_q;

  key_state_t add_q, add_d, sub_q, sub_d;
  event_e     latched_q, latched_d, event_now;
  logic       pending_q, pending_d, pending_now;
  logic       add_acc, sub_acc, poll_any;
  logic       out_load, item_adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout <= LockoutReset;
      cfg_q.stable  <= StableReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxLockout) begin
        cfg_q.lockout <= cfg_data_i;
      end else if (cfg_index_i == CfgIdxStable) begin
        cfg_q.stable <= cfg_data_i;
      end
    end
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign item_adv   = in_valid_q && out_load;
  assign in_ready_o = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q          <= now_ms_i;
      add_smp_q      <= '{level: add_pressed_i, fall: add_fall_i};
      sub_smp_q      <= '{level: sub_pressed_i, fall: sub_fall_i};
      poll_event_q   <= poll_event_i;
      poll_pending_q <= poll_pending_i;
    end
  end

  assign poll_any = poll_event_q || poll_pending_q;

  tkpl_key u_add (
    .state_i  (add_q),
    .sample_i (add_smp_q),
    .now_i    (now_q),
    .poll_i   (poll_any),
    .cfg_i    (cfg_q),
    .state_o  (add_d),
    .accept_o (add_acc)
  );

  tkpl_key u_sub (
    .state_i  (sub_q),
    .sample_i (sub_smp_q),
    .now_i    (now_q),
    .poll_i   (poll_any),
    .cfg_i    (cfg_q),
    .state_o  (sub_d),
    .accept_o (sub_acc)
  );

  // Edges are handled before the polls, and sub overrides add within one request.
  always_comb begin
    pending_now = pending_q || add_smp_q.fall || sub_smp_q.fall;
    priority if (sub_acc) begin
      event_now = EVT_SUB;
    end else if (add_acc) begin
      event_now = EVT_ADD;
    end else begin
      event_now = latched_q;
    end
    pending_d = poll_pending_q ? 1'b0 : pending_now;
    latched_d = poll_event_q ? EVT_NONE : event_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q     <= '{armed: 1'b1, last_press: '0, rel_start: '0};
      sub_q     <= '{armed: 1'b1, last_press: '0, rel_start: '0};
      latched_q <= EVT_NONE;
      pending_q <= 1'b0;
    end else if (item_adv) begin
      add_q     <= add_d;
      sub_q     <= sub_d;
      latched_q <= latched_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_adv) begin
      event_code_q   <= poll_event_q ? event_now : EVT_NONE;
      edge_pending_q <= poll_pending_q && pending_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_code_o   = event_code_q;
  assign edge_pending_o = edge_pending_q;

  `TKPL_ASSERT_NEXT(a_poll_clears_event, item_adv && poll_event_q, latched_q == EVT_NONE)
  `TKPL_ASSERT_NEXT(a_add_press_disarms, item_adv && add_acc, !add_q.armed)
  `TKPL_ASSERT_NEXT(a_stall_keeps_item, in_valid_q && !item_adv, in_valid_q)

endmodule
`default_nettype wire
